/* sv/srt_pkg.sv */
package srt_pkg;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] record_key;
    logic [7:0]  score_a;
    logic [7:0]  score_b;
    logic [7:0]  score_c;
    logic [1:0]  score_slot;
    logic [7:0]  new_score;
  } srt_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] position;
    logic [5:0] entry_count;
    logic [7:0] out_score_a;
    logic [7:0] out_score_b;
    logic [7:0] out_score_c;
  } srt_out_t;

  typedef struct packed {
    logic [15:0] key;
    logic [7:0]  sc_a;
    logic [7:0]  sc_b;
    logic [7:0]  sc_c;
  } srt_rec_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_CHANGE = 2'd2,
    OP_NONE   = 2'd3
  } srt_op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } srt_status_t;

  typedef enum logic [1:0] {
    SLOT_A = 2'd0,
    SLOT_B = 2'd1,
    SLOT_C = 2'd2
  } srt_slot_t;

  typedef enum logic [4:0] {
    ACT_NOP,
    ACT_LOAD,
    ACT_RD_MID,
    ACT_BS_STEP,
    ACT_RD_LO,
    ACT_CHECK,
    ACT_INS_SETUP,
    ACT_SET_FULL,
    ACT_RD_IDXM1,
    ACT_SHIFT_UP,
    ACT_INS_PUT,
    ACT_DEL_SETUP,
    ACT_SET_NF,
    ACT_RD_IDX,
    ACT_SHIFT_DN,
    ACT_DEC_CNT,
    ACT_CHG_WR,
    ACT_FINISH
  } srt_act_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_START,
    C_LO_GE_HI,
    C_IDX_LE_POS,
    C_IDXM1_GT_POS,
    C_IDX_GE_CNT,
    C_IDXP1_LT_CNT,
    C_NOT_FULL,
    C_FOUND,
    C_OP_INS,
    C_OP_DEL,
    C_OP_CHG
  } srt_cond_t;

  localparam int UPC_W = 5;

  typedef logic [UPC_W-1:0] srt_upc_t;

  localparam srt_upc_t U_IDLE      = 5'd0;
  localparam srt_upc_t U_BS_TEST   = 5'd1;
  localparam srt_upc_t U_BS_WAIT   = 5'd2;
  localparam srt_upc_t U_BS_DONE   = 5'd3;
  localparam srt_upc_t U_CHECK     = 5'd4;
  localparam srt_upc_t U_DISP_DEL  = 5'd5;
  localparam srt_upc_t U_DISP_CHG  = 5'd6;
  localparam srt_upc_t U_DISP_NONE = 5'd7;
  localparam srt_upc_t U_INS_TEST  = 5'd8;
  localparam srt_upc_t U_INS_FULL  = 5'd9;
  localparam srt_upc_t U_INS_PRIME = 5'd10;
  localparam srt_upc_t U_INS_SHIFT = 5'd11;
  localparam srt_upc_t U_INS_PUT   = 5'd12;
  localparam srt_upc_t U_DEL_TEST  = 5'd13;
  localparam srt_upc_t U_DEL_NF    = 5'd14;
  localparam srt_upc_t U_DEL_PRIME = 5'd15;
  localparam srt_upc_t U_DEL_SHIFT = 5'd16;
  localparam srt_upc_t U_DEL_DONE  = 5'd17;
  localparam srt_upc_t U_CHG_TEST  = 5'd18;
  localparam srt_upc_t U_CHG_NF    = 5'd19;
  localparam srt_upc_t U_CHG_WR    = 5'd20;
  localparam srt_upc_t U_DONE      = 5'd21;

  typedef struct packed {
    srt_act_t  act;
    srt_cond_t cond;
    srt_upc_t  target;
  } srt_uword_t;

  typedef struct packed {
    logic start;
    logic lo_ge_hi;
    logic idx_le_pos;
    logic idxm1_gt_pos;
    logic idx_ge_cnt;
    logic idxp1_lt_cnt;
    logic not_full;
    logic found;
    logic op_ins;
    logic op_del;
    logic op_chg;
  } srt_flags_t;

  function automatic srt_uword_t uw(input srt_act_t act, input srt_cond_t cond,
                                    input srt_upc_t target);
    srt_uword_t w;
    w.act    = act;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // control store: jump to target when cond holds, else step on
  function automatic srt_uword_t srt_ucode(input srt_upc_t upc);
    srt_uword_t w;
    case (upc)
      U_IDLE:      w = uw(ACT_LOAD,      C_NO_START,     U_IDLE);
      U_BS_TEST:   w = uw(ACT_RD_MID,    C_LO_GE_HI,     U_BS_DONE);
      U_BS_WAIT:   w = uw(ACT_BS_STEP,   C_ALWAYS,       U_BS_TEST);
      U_BS_DONE:   w = uw(ACT_RD_LO,     C_NEVER,        U_IDLE);
      U_CHECK:     w = uw(ACT_CHECK,     C_OP_INS,       U_INS_TEST);
      U_DISP_DEL:  w = uw(ACT_NOP,       C_OP_DEL,       U_DEL_TEST);
      U_DISP_CHG:  w = uw(ACT_NOP,       C_OP_CHG,       U_CHG_TEST);
      U_DISP_NONE: w = uw(ACT_NOP,       C_ALWAYS,       U_DONE);
      U_INS_TEST:  w = uw(ACT_INS_SETUP, C_NOT_FULL,     U_INS_PRIME);
      U_INS_FULL:  w = uw(ACT_SET_FULL,  C_ALWAYS,       U_DONE);
      U_INS_PRIME: w = uw(ACT_RD_IDXM1,  C_IDX_LE_POS,   U_INS_PUT);
      U_INS_SHIFT: w = uw(ACT_SHIFT_UP,  C_IDXM1_GT_POS, U_INS_SHIFT);
      U_INS_PUT:   w = uw(ACT_INS_PUT,   C_ALWAYS,       U_DONE);
      U_DEL_TEST:  w = uw(ACT_DEL_SETUP, C_FOUND,        U_DEL_PRIME);
      U_DEL_NF:    w = uw(ACT_SET_NF,    C_ALWAYS,       U_DONE);
      U_DEL_PRIME: w = uw(ACT_RD_IDX,    C_IDX_GE_CNT,   U_DEL_DONE);
      U_DEL_SHIFT: w = uw(ACT_SHIFT_DN,  C_IDXP1_LT_CNT, U_DEL_SHIFT);
      U_DEL_DONE:  w = uw(ACT_DEC_CNT,   C_ALWAYS,       U_DONE);
      U_CHG_TEST:  w = uw(ACT_NOP,       C_FOUND,        U_CHG_WR);
      U_CHG_NF:    w = uw(ACT_SET_NF,    C_ALWAYS,       U_DONE);
      U_CHG_WR:    w = uw(ACT_CHG_WR,    C_ALWAYS,       U_DONE);
      U_DONE:      w = uw(ACT_FINISH,    C_ALWAYS,       U_IDLE);
      default:     w = uw(ACT_NOP,       C_ALWAYS,       U_IDLE);
    endcase
    return w;
  endfunction

endpackage

/* sv/srt_mem.sv */
module srt_mem #(
  parameter int ADDR_W = 5
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  output srt_pkg::srt_rec_t    rd_data,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  srt_pkg::srt_rec_t    wr_data
);

  srt_pkg::srt_rec_t mem [0:(1<<ADDR_W)-1];
  srt_pkg::srt_rec_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/srt_seq.sv */
module srt_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  srt_pkg::srt_flags_t flags,
  output srt_pkg::srt_act_t   act,
  output logic                busy
);

  srt_pkg::srt_upc_t  upc_r, upc_nxt;
  srt_pkg::srt_uword_t word;
  logic                take;

  assign word = srt_pkg::srt_ucode(upc_r);

  always_comb begin
    case (word.cond)
      srt_pkg::C_NEVER:        take = 1'b0;
      srt_pkg::C_ALWAYS:       take = 1'b1;
      srt_pkg::C_NO_START:     take = !flags.start;
      srt_pkg::C_LO_GE_HI:     take = flags.lo_ge_hi;
      srt_pkg::C_IDX_LE_POS:   take = flags.idx_le_pos;
      srt_pkg::C_IDXM1_GT_POS: take = flags.idxm1_gt_pos;
      srt_pkg::C_IDX_GE_CNT:   take = flags.idx_ge_cnt;
      srt_pkg::C_IDXP1_LT_CNT: take = flags.idxp1_lt_cnt;
      srt_pkg::C_NOT_FULL:     take = flags.not_full;
      srt_pkg::C_FOUND:        take = flags.found;
      srt_pkg::C_OP_INS:       take = flags.op_ins;
      srt_pkg::C_OP_DEL:       take = flags.op_del;
      srt_pkg::C_OP_CHG:       take = flags.op_chg;
      default:                 take = 1'b0;
    endcase
  end

  always_comb begin
    if (take) begin
      upc_nxt = word.target;
    end else begin
      upc_nxt = upc_r + srt_pkg::srt_upc_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= srt_pkg::U_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  assign act  = word.act;
  assign busy = (upc_r != srt_pkg::U_IDLE);

endmodule

/* sv/sorted_record_table.sv */
// sorted record table: keeps up to TABLE_DEPTH records ordered by key
// input: drive in_item and raise start; the item is taken on an edge with
// start high and busy low. busy stays high until the result has been formed.
// output: out_item is valid for exactly one cycle while out_strobe is high;
// the receiver cannot stall, so it must capture the beat in that cycle.
// each item gives exactly one result: status, lower-bound position, count
// and the scores of the record it touched.
// control: a small microcode table sequences each item; every search halving
// is a record-memory read followed by a compare, and each step of a shift
// writes one record while it reads the next, so reads and writes overlap.
// the search makes up to ceil(log2(count+1)) halvings, then insert or delete
// shifts the records from the position upward; a new item is taken in the
// strobe cycle.
// reset: the count and sequencer clear at once, no clearing pass is run;
// record memory contents are only used below the count.
module sorted_record_table #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  srt_pkg::srt_in_t   in_item,
  output logic               out_strobe,
  output srt_pkg::srt_out_t  out_item
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  srt_pkg::srt_act_t   act;
  srt_pkg::srt_flags_t flags;

  srt_pkg::srt_in_t  in_r, in_nxt;
  srt_pkg::srt_rec_t rec_r, rec_nxt;
  srt_pkg::srt_out_t out_r, out_nxt;
  logic [CW-1:0]     lo_r, lo_nxt;
  logic [CW-1:0]     hi_r, hi_nxt;
  logic [CW-1:0]     mid_r, mid_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              found_r, found_nxt;
  logic              strobe_r, strobe_nxt;

  logic [CW-1:0]     mid_c;
  logic [CW-1:0]     idx_m1;
  logic [CW-1:0]     idx_m2;
  logic [CW:0]       idx_p1_w;
  logic [CW+5:0]     pos_wide;
  logic [CW+5:0]     cnt_wide;

  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  srt_pkg::srt_rec_t rd_data;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  srt_pkg::srt_rec_t wr_data;
  srt_pkg::srt_rec_t new_rec;
  srt_pkg::srt_rec_t chg_rec;

  srt_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .act   (act),
    .busy  (busy)
  );

  srt_mem #(
    .ADDR_W (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign mid_c    = lo_r + ((hi_r - lo_r) >> 1);
  assign idx_m1   = idx_r - CW'(1);
  assign idx_m2   = idx_r - CW'(2);
  assign idx_p1_w = {1'b0, idx_r} + (CW+1)'(1);
  assign pos_wide = {6'b0, lo_r};
  assign cnt_wide = {6'b0, cnt_r};

  always_comb begin
    flags.start        = start;
    flags.lo_ge_hi     = (lo_r >= hi_r);
    flags.idx_le_pos   = (idx_r <= lo_r);
    flags.idxm1_gt_pos = (idx_m1 > lo_r);
    flags.idx_ge_cnt   = (idx_r >= cnt_r);
    flags.idxp1_lt_cnt = (idx_p1_w < {1'b0, cnt_r});
    flags.not_full     = (cnt_r < DEPTH_C);
    flags.found        = found_r;
    flags.op_ins       = (in_r.opcode == srt_pkg::OP_INSERT);
    flags.op_del       = (in_r.opcode == srt_pkg::OP_DELETE);
    flags.op_chg       = (in_r.opcode == srt_pkg::OP_CHANGE);
  end

  always_comb begin
    new_rec.key  = in_r.record_key;
    new_rec.sc_a = in_r.score_a;
    new_rec.sc_b = in_r.score_b;
    new_rec.sc_c = in_r.score_c;
  end

  // slot three leaves the record as it was
  always_comb begin
    chg_rec = rec_r;
    case (in_r.score_slot)
      srt_pkg::SLOT_A: chg_rec.sc_a = in_r.new_score;
      srt_pkg::SLOT_B: chg_rec.sc_b = in_r.new_score;
      srt_pkg::SLOT_C: chg_rec.sc_c = in_r.new_score;
      default:         chg_rec = rec_r;
    endcase
  end

  always_comb begin
    in_nxt     = in_r;
    rec_nxt    = rec_r;
    out_nxt    = out_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    mid_nxt    = mid_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    found_nxt  = found_r;
    strobe_nxt = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = rd_data;
    case (act)
      srt_pkg::ACT_LOAD: begin
        if (start) begin
          in_nxt = in_item;
          lo_nxt = '0;
          hi_nxt = cnt_r;
        end
      end
      srt_pkg::ACT_RD_MID: begin
        rd_en   = 1'b1;
        rd_addr = mid_c[AW-1:0];
        mid_nxt = mid_c;
      end
      srt_pkg::ACT_BS_STEP: begin
        if (rd_data.key < in_r.record_key) begin
          lo_nxt = mid_r + CW'(1);
        end else begin
          hi_nxt = mid_r;
        end
      end
      srt_pkg::ACT_RD_LO: begin
        rd_en   = 1'b1;
        rd_addr = lo_r[AW-1:0];
      end
      srt_pkg::ACT_CHECK: begin
        rec_nxt             = rd_data;
        found_nxt           = (lo_r < cnt_r) && (rd_data.key == in_r.record_key);
        out_nxt.status      = srt_pkg::ST_OK;
        out_nxt.out_score_a = '0;
        out_nxt.out_score_b = '0;
        out_nxt.out_score_c = '0;
      end
      srt_pkg::ACT_INS_SETUP: begin
        idx_nxt = cnt_r;
      end
      srt_pkg::ACT_SET_FULL: begin
        out_nxt.status = srt_pkg::ST_FULL;
      end
      srt_pkg::ACT_RD_IDXM1: begin
        rd_en   = 1'b1;
        rd_addr = idx_m1[AW-1:0];
      end
      // write the record read last beat one place up, fetch the next one down
      srt_pkg::ACT_SHIFT_UP: begin
        wr_en   = 1'b1;
        wr_addr = idx_r[AW-1:0];
        wr_data = rd_data;
        rd_en   = 1'b1;
        rd_addr = idx_m2[AW-1:0];
        idx_nxt = idx_m1;
      end
      srt_pkg::ACT_INS_PUT: begin
        wr_en               = 1'b1;
        wr_addr             = lo_r[AW-1:0];
        wr_data             = new_rec;
        cnt_nxt             = cnt_r + CW'(1);
        out_nxt.out_score_a = in_r.score_a;
        out_nxt.out_score_b = in_r.score_b;
        out_nxt.out_score_c = in_r.score_c;
      end
      srt_pkg::ACT_DEL_SETUP: begin
        idx_nxt             = lo_r + CW'(1);
        out_nxt.out_score_a = rec_r.sc_a;
        out_nxt.out_score_b = rec_r.sc_b;
        out_nxt.out_score_c = rec_r.sc_c;
      end
      srt_pkg::ACT_SET_NF: begin
        out_nxt.status      = srt_pkg::ST_NOT_FOUND;
        out_nxt.out_score_a = '0;
        out_nxt.out_score_b = '0;
        out_nxt.out_score_c = '0;
      end
      srt_pkg::ACT_RD_IDX: begin
        rd_en   = 1'b1;
        rd_addr = idx_r[AW-1:0];
      end
      srt_pkg::ACT_SHIFT_DN: begin
        wr_en   = 1'b1;
        wr_addr = idx_m1[AW-1:0];
        wr_data = rd_data;
        rd_en   = 1'b1;
        rd_addr = idx_p1_w[AW-1:0];
        idx_nxt = idx_p1_w[CW-1:0];
      end
      srt_pkg::ACT_DEC_CNT: begin
        cnt_nxt = cnt_r - CW'(1);
      end
      srt_pkg::ACT_CHG_WR: begin
        wr_en               = 1'b1;
        wr_addr             = lo_r[AW-1:0];
        wr_data             = chg_rec;
        out_nxt.out_score_a = chg_rec.sc_a;
        out_nxt.out_score_b = chg_rec.sc_b;
        out_nxt.out_score_c = chg_rec.sc_c;
      end
      srt_pkg::ACT_FINISH: begin
        out_nxt.position    = pos_wide[5:0];
        out_nxt.entry_count = cnt_wide[5:0];
        strobe_nxt          = 1'b1;
      end
      default: begin
        strobe_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r    <= in_nxt;
    rec_r   <= rec_nxt;
    out_r   <= out_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    idx_r   <= idx_nxt;
    found_r <= found_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_item   = out_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("record count above table depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not start the sequencer");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_item.status == srt_pkg::ST_FULL)) |-> (cnt_r == DEPTH_C))
    else $error("full reported while table has room");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && (act == srt_pkg::ACT_SHIFT_UP)) |-> (idx_r < DEPTH_C))
    else $error("shift writes past table end");

endmodule

/* dv/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 80;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 92;

  // tracks the table contents and the results it should produce, in order
  class record_table_tracker;
    srt_pkg::srt_rec_t recs[DEPTH];
    int unsigned       count;
    srt_pkg::srt_out_t pending_results[$];
    int unsigned       errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    function void note_accepted(srt_pkg::srt_in_t it);
      srt_pkg::srt_out_t r;
      int unsigned lo, hi, mid, pos;
      bit          hit;
      lo = 0;
      hi = count;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (recs[mid].key < it.record_key) lo = mid + 1;
        else hi = mid;
      end
      pos = lo;
      hit = (pos < count) && (recs[pos].key == it.record_key);
      r = '0;
      r.status = srt_pkg::ST_OK;
      case (srt_pkg::srt_op_t'(it.opcode))
        srt_pkg::OP_INSERT: begin
          if (count >= DEPTH) begin
            r.status = srt_pkg::ST_FULL;
          end else begin
            for (int i = count; i > pos; i--) recs[i] = recs[i-1];
            recs[pos].key  = it.record_key;
            recs[pos].sc_a = it.score_a;
            recs[pos].sc_b = it.score_b;
            recs[pos].sc_c = it.score_c;
            count++;
            r.out_score_a = it.score_a;
            r.out_score_b = it.score_b;
            r.out_score_c = it.score_c;
          end
        end
        srt_pkg::OP_DELETE: begin
          if (!hit) begin
            r.status = srt_pkg::ST_NOT_FOUND;
          end else begin
            r.out_score_a = recs[pos].sc_a;
            r.out_score_b = recs[pos].sc_b;
            r.out_score_c = recs[pos].sc_c;
            for (int i = pos + 1; i < count; i++) recs[i-1] = recs[i];
            count--;
          end
        end
        srt_pkg::OP_CHANGE: begin
          if (!hit) begin
            r.status = srt_pkg::ST_NOT_FOUND;
          end else begin
            // slot three writes nothing but still reports the record
            case (it.score_slot)
              srt_pkg::SLOT_A: recs[pos].sc_a = it.new_score;
              srt_pkg::SLOT_B: recs[pos].sc_b = it.new_score;
              srt_pkg::SLOT_C: recs[pos].sc_c = it.new_score;
              default: ;
            endcase
            r.out_score_a = recs[pos].sc_a;
            r.out_score_b = recs[pos].sc_b;
            r.out_score_c = recs[pos].sc_c;
          end
        end
        default: ;
      endcase
      r.position    = pos[5:0];
      r.entry_count = count[5:0];
      pending_results.push_back(r);
    endfunction

    function void compare_field(string fname, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected %0h actual %0h", $time, fname, want, got);
      end
    endfunction

    function void check_result(srt_pkg::srt_out_t got);
      srt_pkg::srt_out_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("position", want.position, got.position);
      compare_field("entry_count", want.entry_count, got.entry_count);
      compare_field("out_score_a", want.out_score_a, got.out_score_a);
      compare_field("out_score_b", want.out_score_b, got.out_score_b);
      compare_field("out_score_c", want.out_score_c, got.out_score_c);
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  srt_pkg::srt_in_t  in_item;
  logic              out_strobe;
  srt_pkg::srt_out_t out_item;

  record_table_tracker sb;
  int cycles = 0;
  int idle_max;

  sorted_record_table #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  initial begin
    clk     = 1'b0;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) sb.check_result(out_item);
      if (start && !busy) sb.note_accepted(in_item);
    end
  end

  function automatic srt_pkg::srt_in_t mk(srt_pkg::srt_op_t op, logic [15:0] key,
                                          logic [7:0] a, logic [7:0] b, logic [7:0] c,
                                          logic [1:0] slot, logic [7:0] ns);
    srt_pkg::srt_in_t it;
    it.opcode     = op;
    it.record_key = key;
    it.score_a    = a;
    it.score_b    = b;
    it.score_c    = c;
    it.score_slot = slot;
    it.new_score  = ns;
    return it;
  endfunction

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_item(srt_pkg::srt_in_t it);
    int gap;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item <= it;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic srt_pkg::srt_in_t random_item(int ins_pct);
    srt_pkg::srt_in_t it;
    int               r;
    srt_pkg::srt_op_t op;
    logic [15:0]      key;
    r = $urandom_range(0, 99);
    if (r < 4) op = srt_pkg::OP_NONE;
    else if (r < 4 + ins_pct) op = srt_pkg::OP_INSERT;
    else if ($urandom_range(0, 1)) op = srt_pkg::OP_DELETE;
    else op = srt_pkg::OP_CHANGE;
    if (sb.count > 0 && $urandom_range(0, 1)) begin
      key = sb.recs[$urandom_range(0, sb.count - 1)].key;
    end else begin
      case ($urandom_range(0, 3))
        0:       key = 16'($urandom_range(0, 15));
        1:       key = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        default: key = 16'($urandom_range(0, 16'hFFFF));
      endcase
    end
    it = mk(op, key, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
            8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
            8'($urandom_range(0, 255)));
    return it;
  endfunction

  initial begin
    int ins_mix[PHASES];
    int idle_mix[PHASES];
    sb       = new();
    idle_max = 18;
    ins_mix  = '{85, 50, 20, 90, 35, 60, 10, 70};
    idle_mix = '{18, 0, 18, 18, 0, 18, 18, 0};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty table, extremes, duplicates, every score slot, misses
    send_item(mk(srt_pkg::OP_DELETE, 16'h1234, 8'h00, 8'h00, 8'h00, srt_pkg::SLOT_A, 8'h00));
    send_item(mk(srt_pkg::OP_CHANGE, 16'h1234, 8'h00, 8'h00, 8'h00, srt_pkg::SLOT_A, 8'h11));
    send_item(mk(srt_pkg::OP_NONE,   16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 2'd3,            8'hFF));
    send_item(mk(srt_pkg::OP_INSERT, 16'h0000, 8'h00, 8'h00, 8'h00, srt_pkg::SLOT_A, 8'h00));
    send_item(mk(srt_pkg::OP_INSERT, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 2'd3,            8'hFF));
    send_item(mk(srt_pkg::OP_INSERT, 16'h8000, 8'h12, 8'h34, 8'h56, srt_pkg::SLOT_B, 8'h00));
    send_item(mk(srt_pkg::OP_INSERT, 16'h8000, 8'hAA, 8'hBB, 8'hCC, srt_pkg::SLOT_C, 8'h00));
    send_item(mk(srt_pkg::OP_CHANGE, 16'h8000, 8'h00, 8'h00, 8'h00, srt_pkg::SLOT_A, 8'hFF));
    send_item(mk(srt_pkg::OP_CHANGE, 16'h8000, 8'hFF, 8'hFF, 8'hFF, srt_pkg::SLOT_B, 8'h00));
    send_item(mk(srt_pkg::OP_CHANGE, 16'hFFFF, 8'h00, 8'h00, 8'h00, srt_pkg::SLOT_C, 8'h5A));
    send_item(mk(srt_pkg::OP_CHANGE, 16'h0000, 8'h00, 8'h00, 8'h00, 2'd3,            8'hFF));
    send_item(mk(srt_pkg::OP_CHANGE, 16'h7FFF, 8'h00, 8'h00, 8'h00, srt_pkg::SLOT_A, 8'h01));
    send_item(mk(srt_pkg::OP_DELETE, 16'h8001, 8'h00, 8'h00, 8'h00, srt_pkg::SLOT_A, 8'h00));
    send_item(mk(srt_pkg::OP_DELETE, 16'h8000, 8'h00, 8'h00, 8'h00, srt_pkg::SLOT_A, 8'h00));
    send_item(mk(srt_pkg::OP_DELETE, 16'hFFFF, 8'h00, 8'h00, 8'h00, srt_pkg::SLOT_A, 8'h00));
    send_item(mk(srt_pkg::OP_CHANGE, 16'hFFFF, 8'h00, 8'h00, 8'h00, srt_pkg::SLOT_B, 8'h77));
    send_item(mk(srt_pkg::OP_DELETE, 16'h0000, 8'h00, 8'h00, 8'h00, srt_pkg::SLOT_A, 8'h00));
    send_item(mk(srt_pkg::OP_NONE,   16'h0000, 8'h00, 8'h00, 8'h00, srt_pkg::SLOT_A, 8'h00));
    send_item(mk(srt_pkg::OP_DELETE, 16'h8000, 8'h00, 8'h00, 8'h00, srt_pkg::SLOT_A, 8'h00));
    send_item(mk(srt_pkg::OP_DELETE, 16'h8000, 8'h00, 8'h00, 8'h00, srt_pkg::SLOT_A, 8'h00));

    // phases vary the share of inserts and the idle gaps between items
    for (int p = 0; p < PHASES; p++) begin
      idle_max = idle_mix[p];
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_item(ins_mix[p]));
    end
    start <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.pending_results.size() != 0) begin
      sb.errors += sb.pending_results.size();
      $display("%0t: %0d results never arrived", $time, sb.pending_results.size());
    end
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/srt_pkg.sv
sv/srt_mem.sv
sv/srt_seq.sv
sv/sorted_record_table.sv
dv/testbench.sv
